FILE: hdl/arpcl_pkg.sv
package arpcl_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int QUEUE_DEPTH       = 2;

   localparam int POS_W         = 11;
   localparam int MIN_FRAME_LEN = 42;
   localparam int SENDER_MAC_AT = 22;
   localparam int SENDER_IP_AT  = 28;
   localparam int MAC_BYTES     = 6;
   localparam int IP_BYTES      = 4;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int INDEX_W = 6;

   typedef enum logic [1:0] {
      ST_SHORT    = 2'd0,
      ST_INSERTED = 2'd1,
      ST_UPDATED  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // one finished frame handed from parser to table engine
   typedef struct packed {
      logic              short_frame;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
   } frame_rec_type;

   typedef enum logic {
      BK_IDLE,
      BK_SEARCH
   } back_state_type;

endpackage

FILE: hdl/arpcl_ram.sv
module arpcl_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/arpcl_front.sv
module arpcl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             frame_byte,
   input  logic                   last_byte,
   output logic                   push,
   output arpcl_pkg::frame_rec_type rec
);

   logic [arpcl_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [arpcl_pkg::IP_W-1:0]  ip_ff, ip_in, ip_next;
   logic [arpcl_pkg::MAC_W-1:0] mac_ff, mac_in, mac_next;

   // shift in sender fields at their byte offsets
   always_comb begin
      ip_next  = ip_ff;
      mac_next = mac_ff;
      if (pos_ff inside {[arpcl_pkg::SENDER_MAC_AT :
                          arpcl_pkg::SENDER_MAC_AT + arpcl_pkg::MAC_BYTES - 1]}) begin
         mac_next = {mac_ff[arpcl_pkg::MAC_W-9:0], frame_byte};
      end else if (pos_ff inside {[arpcl_pkg::SENDER_IP_AT :
                                 arpcl_pkg::SENDER_IP_AT + arpcl_pkg::IP_BYTES - 1]}) begin
         ip_next = {ip_ff[arpcl_pkg::IP_W-9:0], frame_byte};
      end
   end

   always_comb begin
      pos_in           = pos_ff;
      ip_in            = ip_ff;
      mac_in           = mac_ff;
      push             = 1'b0;
      rec.short_frame  = pos_ff < arpcl_pkg::POS_W'(arpcl_pkg::MIN_FRAME_LEN - 1);
      rec.ip           = ip_next;
      rec.mac          = mac_next;
      if (accept) begin
         if (last_byte) begin
            push   = 1'b1;
            pos_in = '0;
            ip_in  = '0;
            mac_in = '0;
         end else begin
            ip_in  = ip_next;
            mac_in = mac_next;
            if (pos_ff != arpcl_pkg::POS_MAX) begin
               pos_in = pos_ff + arpcl_pkg::POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ip_ff  <= '0;
         mac_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ip_ff  <= ip_in;
         mac_ff <= mac_in;
      end
   end

endmodule

FILE: hdl/arpcl_queue.sv
module arpcl_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  arpcl_pkg::frame_rec_type push_rec,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output arpcl_pkg::frame_rec_type head
);

   localparam int PtrW = $clog2(arpcl_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(arpcl_pkg::QUEUE_DEPTH + 1);

   arpcl_pkg::frame_rec_type slot_ff [arpcl_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == CntW'(arpcl_pkg::QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == PtrW'(arpcl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

FILE: hdl/arpcl_back.sv
module arpcl_back #(
   parameter int TableEntries = arpcl_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  arpcl_pkg::frame_rec_type   q_head,
   output logic                       q_pop,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [arpcl_pkg::INDEX_W-1:0] rsp_entry_index,
   output logic [arpcl_pkg::IP_W-1:0] rsp_learned_ip,
   output logic [arpcl_pkg::MAC_W-1:0] rsp_learned_mac
);

   localparam int IdxW = $clog2(TableEntries);
   localparam int CntW = $clog2(TableEntries + 1);

   arpcl_pkg::back_state_type state_ff, state_in;
   arpcl_pkg::frame_rec_type  rec_ff, rec_in;

   logic [CntW-1:0] count_ff, count_in;  // entries 0..count-1 are valid
   logic [CntW-1:0] scan_ff, scan_in;
   logic            pend_ff, pend_in;
   logic [IdxW-1:0] pend_idx_ff, pend_idx_in;

   logic                       strobe_ff, strobe_in;
   arpcl_pkg::status_type      res_status_ff, res_status_in;
   logic [arpcl_pkg::INDEX_W-1:0] res_idx_ff, res_idx_in;
   logic [arpcl_pkg::IP_W-1:0]  res_ip_ff, res_ip_in;
   logic [arpcl_pkg::MAC_W-1:0] res_mac_ff, res_mac_in;

   logic                        ip_we, mac_we;
   logic [IdxW-1:0]             wr_addr;
   logic [arpcl_pkg::IP_W-1:0]  ip_rd_data;
   logic                        hit, miss;

   arpcl_ram #(.Width(arpcl_pkg::IP_W), .Depth(TableEntries)) u_ip_ram (
      .clock   (clock),
      .wr_en   (ip_we),
      .wr_addr (wr_addr),
      .wr_data (rec_ff.ip),
      .rd_addr (scan_ff[IdxW-1:0]),
      .rd_data (ip_rd_data)
   );

   arpcl_ram #(.Width(arpcl_pkg::MAC_W), .Depth(TableEntries)) u_mac_ram (
      .clock   (clock),
      .wr_en   (mac_we),
      .wr_addr (wr_addr),
      .wr_data (rec_ff.mac),
      .rd_addr (scan_ff[IdxW-1:0]),
      .rd_data ()
   );

   // first returning match wins; miss once every valid entry has been compared
   always_comb begin
      hit  = pend_ff && (ip_rd_data == rec_ff.ip);
      miss = !hit && (scan_ff == count_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arpcl_pkg::BK_IDLE: begin
            if (q_valid && !q_head.short_frame) begin
               state_in = arpcl_pkg::BK_SEARCH;
            end
         end
         arpcl_pkg::BK_SEARCH: begin
            if (hit || miss) begin
               state_in = arpcl_pkg::BK_IDLE;
            end
         end
         default: state_in = arpcl_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      rec_in        = rec_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      count_in      = count_ff;
      ip_we         = 1'b0;
      mac_we        = 1'b0;
      wr_addr       = count_ff[IdxW-1:0];
      strobe_in     = 1'b0;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_ip_in     = rec_ff.ip;
      res_mac_in    = rec_ff.mac;
      case (state_ff)
         arpcl_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               rec_in  = q_head;
               scan_in = '0;
               if (q_head.short_frame) begin
                  strobe_in     = 1'b1;
                  res_status_in = arpcl_pkg::ST_SHORT;
                  res_idx_in    = '0;
                  res_ip_in     = q_head.ip;
                  res_mac_in    = q_head.mac;
               end
            end
         end
         arpcl_pkg::BK_SEARCH: begin
            if (hit) begin
               mac_we        = 1'b1;
               wr_addr       = pend_idx_ff;
               strobe_in     = 1'b1;
               res_status_in = arpcl_pkg::ST_UPDATED;
               res_idx_in    = arpcl_pkg::INDEX_W'(pend_idx_ff);
            end else if (miss) begin
               strobe_in = 1'b1;
               if (count_ff != CntW'(TableEntries)) begin
                  ip_we         = 1'b1;
                  mac_we        = 1'b1;
                  count_in      = count_ff + CntW'(1);
                  res_status_in = arpcl_pkg::ST_INSERTED;
                  res_idx_in    = arpcl_pkg::INDEX_W'(count_ff[IdxW-1:0]);
               end else begin
                  res_status_in = arpcl_pkg::ST_FULL;
                  res_idx_in    = '0;
               end
            end else begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IdxW-1:0];
               scan_in     = scan_ff + CntW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= arpcl_pkg::BK_IDLE;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff        <= rec_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_ip_ff     <= res_ip_in;
      res_mac_ff    <= res_mac_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = res_status_ff;
   assign rsp_entry_index = res_idx_ff;
   assign rsp_learned_ip  = res_ip_ff;
   assign rsp_learned_mac = res_mac_ff;

endmodule

FILE: hdl/arp_cache_learn.sv
// Bytes: one transaction per cycle while busy is low; busy rises only when the frame queue is full.
// Frame result (table engine idle): rsp_strobe rises once the frame has passed the queue and the
//   result register for a short frame, and after a scan of the used entries otherwise (one IP RAM
//   read per valid entry, pipelined). A frame queued behind another waits for that one to finish.
// Lookup cost grows with used entries, far below a minimum 42-byte frame for small tables.
// Reset (synchronous) empties the table via its fill count and clears the parser; no clearing pass.
// The receiver cannot stall: each result is presented for exactly one cycle.
module arp_cache_learn #(
   parameter int TableEntries = arpcl_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [7:0]                     req_frame_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_status,
   output logic [arpcl_pkg::INDEX_W-1:0]  rsp_entry_index,
   output logic [arpcl_pkg::IP_W-1:0]     rsp_learned_ip,
   output logic [arpcl_pkg::MAC_W-1:0]    rsp_learned_mac
);

   logic                     accept;
   logic                     push;
   logic                     pop;
   logic                     q_full;
   logic                     q_valid;
   arpcl_pkg::frame_rec_type push_rec;
   arpcl_pkg::frame_rec_type q_head;

   // a byte transaction completes on start while the queue has room
   assign busy   = q_full;
   assign accept = start && !busy;

   // front: byte position, sender MAC/IP capture, short-frame classification
   arpcl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_frame_byte),
      .last_byte  (req_last_byte),
      .push       (push),
      .rec        (push_rec)
   );

   // short queue of finished frames decouples parsing from table lookup
   arpcl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   // back: sequential scan of the valid entries, then update, insert or table full; short frames skip it
   arpcl_back #(.TableEntries(TableEntries)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_learned_ip  (rsp_learned_ip),
      .rsp_learned_mac (rsp_learned_mac)
   );

endmodule

FILE: tb/arp_cache_learn_test.sv
module arp_cache_learn_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Expected outcome of one frame.
   typedef struct {
      arpcl_pkg::status_type               status;
      logic [arpcl_pkg::INDEX_W-1:0]       slot;
      logic [arpcl_pkg::IP_W-1:0]          ip;
      logic [arpcl_pkg::MAC_W-1:0]         mac;
   } learn_result_type;

   // Tracks the learning table and the frame parser, and holds the frame
   // outcomes that have not come out of the DUT yet.
   class arp_table_tracker;
      logic [arpcl_pkg::IP_W-1:0]   ip_tab  [arpcl_pkg::TABLE_ENTRIES_DEF];
      logic [arpcl_pkg::MAC_W-1:0]  mac_tab [arpcl_pkg::TABLE_ENTRIES_DEF];
      bit                           in_use  [arpcl_pkg::TABLE_ENTRIES_DEF];
      logic [arpcl_pkg::POS_W-1:0]  frame_pos;
      logic [arpcl_pkg::IP_W-1:0]   cap_ip;
      logic [arpcl_pkg::MAC_W-1:0]  cap_mac;
      learn_result_type             learned_q[$];
      int                           errors;
      int                           n_short, n_insert, n_update, n_full;

      function new();
         foreach (in_use[i]) in_use[i] = 0;
         frame_pos = '0;
         cap_ip    = '0;
         cap_mac   = '0;
         errors    = 0;
         n_short   = 0;
         n_insert  = 0;
         n_update  = 0;
         n_full    = 0;
      endfunction

      function int pending();
         return learned_q.size();
      endfunction

      // One accepted byte transaction.
      function void take_byte(logic [7:0] b, logic last);
         learn_result_type r;
         int               pos;
         bit               hit;
         pos = int'(frame_pos);
         if (pos >= arpcl_pkg::SENDER_MAC_AT &&
             pos < arpcl_pkg::SENDER_MAC_AT + arpcl_pkg::MAC_BYTES)
            cap_mac = {cap_mac[arpcl_pkg::MAC_W-9:0], b};
         else if (pos >= arpcl_pkg::SENDER_IP_AT &&
                  pos < arpcl_pkg::SENDER_IP_AT + arpcl_pkg::IP_BYTES)
            cap_ip = {cap_ip[arpcl_pkg::IP_W-9:0], b};
         if (!last) begin
            if (frame_pos != arpcl_pkg::POS_MAX) frame_pos++;
            return;
         end
         r.slot = '0;
         r.ip   = cap_ip;
         r.mac  = cap_mac;
         if (pos + 1 < arpcl_pkg::MIN_FRAME_LEN) begin
            r.status = arpcl_pkg::ST_SHORT;
            n_short++;
         end else begin
            hit = 0;
            foreach (in_use[i]) begin
               if (!hit && in_use[i] && ip_tab[i] == cap_ip) begin
                  hit     = 1;
                  r.slot  = arpcl_pkg::INDEX_W'(i);
                  mac_tab[i] = cap_mac;
               end
            end
            if (hit) begin
               r.status = arpcl_pkg::ST_UPDATED;
               n_update++;
            end else begin
               r.status = arpcl_pkg::ST_FULL;
               foreach (in_use[i]) begin
                  if (r.status == arpcl_pkg::ST_FULL && !in_use[i]) begin
                     in_use[i]  = 1;
                     ip_tab[i]  = cap_ip;
                     mac_tab[i] = cap_mac;
                     r.slot     = arpcl_pkg::INDEX_W'(i);
                     r.status   = arpcl_pkg::ST_INSERTED;
                  end
               end
               if (r.status == arpcl_pkg::ST_FULL) n_full++;
               else n_insert++;
            end
         end
         learned_q.push_back(r);
         frame_pos = '0;
         cap_ip    = '0;
         cap_mac   = '0;
      endfunction

      // One result strobe, compared against the oldest outstanding frame.
      function void check_rsp(logic [1:0] st, logic [arpcl_pkg::INDEX_W-1:0] slot,
                              logic [arpcl_pkg::IP_W-1:0] ip,
                              logic [arpcl_pkg::MAC_W-1:0] mac);
         learn_result_type want;
         if (learned_q.size() == 0) begin
            $display("%0t: result with no frame outstanding: status %0d slot %0d ip %h mac %h",
                     $time, st, slot, ip, mac);
            errors++;
            return;
         end
         want = learned_q.pop_front();
         if (st !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            errors++;
         end
         if (slot !== want.slot) begin
            $display("%0t: entry_index expected %0d actual %0d", $time, want.slot, slot);
            errors++;
         end
         if (ip !== want.ip) begin
            $display("%0t: learned_ip expected %h actual %h", $time, want.ip, ip);
            errors++;
         end
         if (mac !== want.mac) begin
            $display("%0t: learned_mac expected %h actual %h", $time, want.mac, mac);
            errors++;
         end
      endfunction
   endclass

   localparam int BYTE_TARGET = 1950;  // rough size of the whole run, in bytes
   localparam int TAIL_CYCLES = arpcl_pkg::TABLE_ENTRIES_DEF + 20;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [7:0]                     req_frame_byte;
   logic                           req_last_byte;
   logic                           rsp_strobe;
   logic [1:0]                     rsp_status;
   logic [arpcl_pkg::INDEX_W-1:0]  rsp_entry_index;
   logic [arpcl_pkg::IP_W-1:0]     rsp_learned_ip;
   logic [arpcl_pkg::MAC_W-1:0]    rsp_learned_mac;

   arp_table_tracker tracker = new();

   int                         bytes_sent;
   int                         frames_sent;
   logic [arpcl_pkg::IP_W-1:0] sent_ips[$];   // sender IPs sent so far, reused to provoke hits

   arp_cache_learn dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_frame_byte  (req_frame_byte),
      .req_last_byte   (req_last_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_learned_ip  (rsp_learned_ip),
      .rsp_learned_mac (rsp_learned_mac)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Monitor: everything is sampled at the rising edge, before the DUT's
   // own updates for that edge land. A byte transaction completes when
   // start is high and busy is low; a result is any cycle with the strobe.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) tracker.take_byte(req_frame_byte, req_last_byte);
         if (rsp_strobe)
            tracker.check_rsp(rsp_status, rsp_entry_index, rsp_learned_ip, rsp_learned_mac);
      end
   end

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Present one byte at the falling edge and hold it until it is taken.
   // start stays high on return; the caller's next step either drives the
   // next byte or lowers start at the very next falling edge.
   task automatic drive_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      start          <= 1'b1;
      req_frame_byte <= b;
      req_last_byte  <= last;
      do @(posedge clock); while (busy);
   endtask

   // Sender holds start low for the requested gap; the data lines carry junk meanwhile.
   task automatic idle_gap(input int n);
      repeat (n) begin
         @(negedge clock);
         start          <= 1'b0;
         req_frame_byte <= 8'($urandom);
         req_last_byte  <= 1'($urandom);
      end
   endtask

   // Sender holds off until every outstanding frame has produced its result.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // One frame of len bytes. Sender MAC and IP land at their fixed offsets
   // (if the frame reaches them); every other byte is random filler.
   task automatic send_frame(input int len, input logic [arpcl_pkg::IP_W-1:0] ip,
                             input logic [arpcl_pkg::MAC_W-1:0] mac, input bit calm);
      logic [7:0] b;
      for (int p = 0; p < len; p++) begin
         if (p >= arpcl_pkg::SENDER_MAC_AT &&
             p < arpcl_pkg::SENDER_MAC_AT + arpcl_pkg::MAC_BYTES)
            b = mac[(arpcl_pkg::MAC_BYTES - 1 - (p - arpcl_pkg::SENDER_MAC_AT)) * 8 +: 8];
         else if (p >= arpcl_pkg::SENDER_IP_AT &&
                  p < arpcl_pkg::SENDER_IP_AT + arpcl_pkg::IP_BYTES)
            b = ip[(arpcl_pkg::IP_BYTES - 1 - (p - arpcl_pkg::SENDER_IP_AT)) * 8 +: 8];
         else
            b = 8'($urandom);
         drive_byte(b, p == len - 1);
         bytes_sent++;
         if (!calm) idle_gap(pick_gap());
      end
      frames_sent++;
      sent_ips.push_back(ip);
   endtask

   initial begin
      int                          r;
      int                          len;
      bit                          calm;
      logic [arpcl_pkg::IP_W-1:0]  ip;
      logic [arpcl_pkg::MAC_W-1:0] mac;

      reset          = 1'b1;
      start          = 1'b0;
      req_frame_byte = '0;
      req_last_byte  = 1'b0;
      bytes_sent     = 0;
      frames_sent    = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames.
      // Single-byte frame: last on the very first byte, nothing captured.
      send_frame(1, 32'hDEAD_BEEF, 48'h1111_2222_3333, 1'b0);
      // Short frames that stop inside the MAC field, inside the IP field,
      // and one byte under the minimum length.
      send_frame(25, 32'hC0A8_0001, 48'hA1B2_C3D4_E5F6, 1'b1);
      send_frame(30, 32'h0A00_0001, 48'h0102_0304_0506, 1'b0);
      send_frame(arpcl_pkg::MIN_FRAME_LEN - 1, '1, '1, 1'b1);
      // Minimum-length frames with all-zero and all-ones fields: two inserts.
      send_frame(arpcl_pkg::MIN_FRAME_LEN, '0, '0, 1'b0);
      send_frame(arpcl_pkg::MIN_FRAME_LEN, '1, '1, 1'b1);
      // Same IP again with a new MAC: update in place.
      send_frame(arpcl_pkg::MIN_FRAME_LEN + 3, '1, 48'h0123_4567_89AB, 1'b0);
      // Long frame: bytes past the sender fields are ignored.
      send_frame(300, 32'h5555_AAAA, 48'hAAAA_5555_AAAA, 1'b1);
      // Update of the all-zero IP after the long frame.
      send_frame(60, '0, 48'h8000_0000_0001, 1'b0);
      // Hold off the sender until the table engine has caught up.
      drain();

      // Random frames: mostly well formed, with fresh or repeated sender
      // IPs, plus short and occasional long frames.
      while (bytes_sent < BYTE_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 10) len = $urandom_range(1, arpcl_pkg::MIN_FRAME_LEN - 1);
         else if (r == 10) len = $urandom_range(100, 300);
         else len = $urandom_range(arpcl_pkg::MIN_FRAME_LEN, 64);
         if ($urandom_range(0, 99) < 30) ip = sent_ips[$urandom_range(0, sent_ips.size() - 1)];
         else ip = $urandom;
         mac  = {16'($urandom), 32'($urandom)};
         calm = ($urandom_range(0, 99) < 30);
         send_frame(len, ip, mac, calm);
         // Now and then let everything drain mid-run.
         if ($urandom_range(0, 99) < 3) drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d frames (%0d bytes): %0d short, %0d inserted, %0d updated, %0d dropped",
               frames_sent, bytes_sent, tracker.n_short, tracker.n_insert, tracker.n_update,
               tracker.n_full);
      if (tracker.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Timed out with %0d frame results outstanding", tracker.pending());
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: arp_cache_learn.f
hdl/arpcl_pkg.sv
hdl/arpcl_ram.sv
hdl/arpcl_front.sv
hdl/arpcl_queue.sv
hdl/arpcl_back.sv
hdl/arp_cache_learn.sv
tb/arp_cache_learn_test.sv
